@@ design/pmc_pkg.sv @@
// Shared types and constants for the maze carver.
package pmc_pkg;

    // Default cell count along one side of the maze
    localparam int SIDE_DEF = 64;

    // Width of the random word and of the divider's dividend
    localparam int RAND_W = 16;

    // Field widths of the request and result
    localparam int START_W = 6;
    localparam int POS_W   = 8;
    localparam int ADDED_W = 3;
    localparam int FSIZE_W = 13;

    // Request codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Cell colours, plus a code for a neighbour that lies off the grid
    typedef logic [1:0] t_cell;
    localparam t_cell CELL_BLACK  = 2'd0;
    localparam t_cell CELL_MARKED = 2'd1;
    localparam t_cell CELL_WHITE  = 2'd2;
    localparam t_cell CELL_NONE   = 2'd3;

    // Datapath operations, one issued by the controller each cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_R,
        OP_TAKE_XY,
        OP_TAKE_P,
        OP_CLR_INIT,
        OP_CLR,
        OP_WR_START,
        OP_RD_PICK,
        OP_RD_LAST,
        OP_MOVE,
        OP_NB_RD,
        OP_NB_GET,
        OP_JOIN,
        OP_MARK,
        OP_OUT,
        OP_IDLE_OUT
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        t_op  op;
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic div_busy;
        logic count_zero;
        logic clr_last;
        logic nb_last;
    } t_stat;

endpackage

@@ design/pmc_div.sv @@
// Restoring divider that yields the remainder, one quotient bit per cycle.
module pmc_div import pmc_pkg::*; #(
    parameter int DVW = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [RAND_W-1:0] i_dividend,
    input  logic [DVW-1:0]    i_divisor,
    output logic              o_busy,
    output logic [DVW-1:0]    o_rem
);

    localparam int CNT_W = $clog2(RAND_W);

    logic [RAND_W-1:0] r_q;
    logic [DVW-1:0]    r_rem;
    logic [DVW-1:0]    r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [DVW:0]      trial;
    logic [DVW:0]      n_rem;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        trial = {r_rem, r_q[RAND_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RAND_W - 1);
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[RAND_W-2:0], 1'b0};
            r_rem <= n_rem[DVW-1:0];
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

@@ design/pmc_dp.sv @@
// Datapath: grid and frontier memories, divider, cell registers and result.
module pmc_dp import pmc_pkg::*; #(
    parameter int SIDE = SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  logic               i_cmd,
    input  logic [START_W-1:0] i_start_x,
    input  logic [START_W-1:0] i_start_y,
    input  logic [RAND_W-1:0]  i_random_word,
    output t_stat              o_stat,
    output logic               o_valid,
    output logic [POS_W-1:0]   o_cell_x,
    output logic [POS_W-1:0]   o_cell_y,
    output logic               o_joined,
    output logic [POS_W-1:0]   o_wall_x,
    output logic [POS_W-1:0]   o_wall_y,
    output logic [ADDED_W-1:0] o_added,
    output logic [FSIZE_W-1:0] o_frontier_size,
    output logic               o_idle
);

    localparam int CW     = $clog2(SIDE);
    localparam int GAW    = 2 * CW;
    localparam int GDEPTH = 1 << GAW;
    localparam int CAP    = SIDE * SIDE;
    localparam int IW     = $clog2(CAP);
    localparam int CNTW   = $clog2(CAP + 1);

    // Reciprocal of SIDE for folding a start coordinate into range
    localparam int FOLD_SH = 14;
    localparam int FOLD_W  = START_W + FOLD_SH;
    localparam int FOLD_M  = ((1 << FOLD_SH) + SIDE - 1) / SIDE;

    // Memories
    t_cell          gmem [GDEPTH];
    logic [GAW-1:0] lmem [CAP];

    // Request and cell registers
    logic               r_is_start;
    logic [START_W-1:0] r_sx;
    logic [START_W-1:0] r_sy;
    logic [RAND_W-1:0]  r_rand;
    logic [CW-1:0]      r_cx;
    logic [CW-1:0]      r_cy;
    logic [IW-1:0]      r_pick;
    logic [CNTW-1:0]    r_count;
    logic [GAW-1:0]     r_clr;
    logic [1:0]         r_nb;
    t_cell              r_nbv [4];
    t_cell              r_grd;
    logic [GAW-1:0]     r_lrd;
    logic               r_joined;
    logic [POS_W-1:0]   r_wx;
    logic [POS_W-1:0]   r_wy;
    logic [ADDED_W-1:0] r_added;

    // Divider hookup
    logic              div_go;
    logic              div_busy;
    logic [CNTW-1:0]   div_rem;

    // Neighbour of the current cell selected by r_nb
    logic [CW-1:0]  nx;
    logic [CW-1:0]  ny;
    logic           n_inb;

    // Join search
    logic           j_found;
    logic [1:0]     j_dir;
    logic [POS_W-1:0] j_wx;
    logic [POS_W-1:0] j_wy;

    // Memory ports
    logic           g_we;
    logic [GAW-1:0] g_waddr;
    t_cell          g_wdata;
    logic           l_we;
    logic [IW-1:0]  l_waddr;
    logic [GAW-1:0] l_wdata;
    logic [IW-1:0]  l_raddr;
    logic           can_add;
    logic [IW-1:0]  last_idx;

    // Fold a start coordinate modulo SIDE by reciprocal multiplication
    function automatic logic [CW-1:0] fold_cell(logic [START_W-1:0] v);
        logic [FOLD_W-1:0]  prod;
        logic [START_W-1:0] quo;
        prod = FOLD_W'(v) * FOLD_W'(FOLD_M);
        quo  = prod[FOLD_W-1:FOLD_SH];
        return CW'(v - START_W'(int'(quo) * SIDE));
    endfunction

    // Start the divider on the pick operation
    assign div_go = (i_ctrl.op == OP_DIV_R);

    pmc_div #(
        .DVW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (r_rand),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    // Select neighbour in north, south, east, west order
    always_comb begin
        nx    = r_cx;
        ny    = r_cy;
        n_inb = 1'b0;
        unique case (r_nb)
            2'd0: begin
                ny    = r_cy - CW'(1);
                n_inb = (r_cy != '0);
            end
            2'd1: begin
                ny    = r_cy + CW'(1);
                n_inb = (r_cy != CW'(SIDE - 1));
            end
            2'd2: begin
                nx    = r_cx + CW'(1);
                n_inb = (r_cx != CW'(SIDE - 1));
            end
            default: begin
                nx    = r_cx - CW'(1);
                n_inb = (r_cx != '0);
            end
        endcase
    end

    // Find the first white neighbour
    always_comb begin
        j_found = 1'b0;
        j_dir   = 2'd0;
        for (int d = 3; d >= 0; d--) begin
            if (r_nbv[d] == CELL_WHITE) begin
                j_found = 1'b1;
                j_dir   = 2'(d);
            end
        end
    end

    // Wall position between the cell and the chosen neighbour
    always_comb begin
        unique case (j_dir)
            2'd0: begin
                j_wx = POS_W'({r_cx, 1'b1});
                j_wy = POS_W'({r_cy, 1'b0});
            end
            2'd1: begin
                j_wx = POS_W'({r_cx, 1'b1});
                j_wy = POS_W'({({1'b0, r_cy} + (CW + 1)'(1)), 1'b0});
            end
            2'd2: begin
                j_wx = POS_W'({({1'b0, r_cx} + (CW + 1)'(1)), 1'b0});
                j_wy = POS_W'({r_cy, 1'b1});
            end
            default: begin
                j_wx = POS_W'({r_cx, 1'b0});
                j_wy = POS_W'({r_cy, 1'b1});
            end
        endcase
    end

    assign can_add  = (r_nbv[r_nb] == CELL_BLACK) && (r_count < CNTW'(CAP));
    assign last_idx = IW'(r_count - CNTW'(1));

    // Grid write port
    always_comb begin
        g_we    = 1'b0;
        g_waddr = {ny, nx};
        g_wdata = CELL_MARKED;
        unique case (i_ctrl.op)
            OP_CLR: begin
                g_we    = 1'b1;
                g_waddr = r_clr;
                g_wdata = CELL_BLACK;
            end
            OP_WR_START: begin
                g_we    = 1'b1;
                g_waddr = {r_cy, r_cx};
                g_wdata = CELL_WHITE;
            end
            OP_JOIN: begin
                g_we    = j_found;
                g_waddr = {r_cy, r_cx};
                g_wdata = CELL_WHITE;
            end
            OP_MARK: begin
                g_we = can_add;
            end
            default: begin
                g_we = 1'b0;
            end
        endcase
    end

    // Frontier list ports
    always_comb begin
        l_we    = 1'b0;
        l_waddr = r_pick;
        l_wdata = r_lrd;
        l_raddr = (i_ctrl.op == OP_RD_LAST) ? last_idx : r_pick;
        unique case (i_ctrl.op)
            OP_MOVE: begin
                l_we = 1'b1;
            end
            OP_MARK: begin
                l_we    = can_add;
                l_waddr = r_count[IW-1:0];
                l_wdata = {ny, nx};
            end
            default: begin
                l_we = 1'b0;
            end
        endcase
    end

    // Memories with registered reads
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            gmem[g_waddr] <= g_wdata;
        end
        r_grd <= gmem[{ny, nx}];
        if (l_we) begin
            lmem[l_waddr] <= l_wdata;
        end
        r_lrd <= lmem[l_raddr];
    end

    // Control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_nb    <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_ctrl.op == OP_OUT) || (i_ctrl.op == OP_IDLE_OUT);
            if (i_ctrl.accept) begin
                r_nb <= '0;
            end
            unique case (i_ctrl.op)
                OP_CLR_INIT: begin
                    r_count <= '0;
                end
                OP_MOVE: begin
                    r_count <= r_count - CNTW'(1);
                end
                OP_NB_GET: begin
                    r_nb <= r_nb + 2'd1;
                end
                OP_MARK: begin
                    r_nb <= r_nb + 2'd1;
                    if (can_add) begin
                        r_count <= r_count + CNTW'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_is_start <= (i_cmd == CMD_START);
            r_sx       <= i_start_x;
            r_sy       <= i_start_y;
            r_rand     <= i_random_word;
            r_joined   <= 1'b0;
            r_wx       <= '0;
            r_wy       <= '0;
            r_added    <= '0;
        end
        unique case (i_ctrl.op)
            OP_TAKE_XY: begin
                r_cx <= fold_cell(r_sx);
                r_cy <= fold_cell(r_sy);
            end
            OP_TAKE_P: begin
                r_pick <= div_rem[IW-1:0];
            end
            OP_CLR_INIT: begin
                r_clr <= '0;
            end
            OP_CLR: begin
                r_clr <= r_clr + GAW'(1);
            end
            OP_RD_LAST: begin
                r_cx <= r_lrd[CW-1:0];
                r_cy <= r_lrd[GAW-1:CW];
            end
            OP_NB_GET: begin
                r_nbv[r_nb] <= n_inb ? r_grd : CELL_NONE;
            end
            OP_JOIN: begin
                if (j_found) begin
                    r_joined <= 1'b1;
                    r_wx     <= j_wx;
                    r_wy     <= j_wy;
                end
            end
            OP_MARK: begin
                if (can_add) begin
                    r_added <= r_added + ADDED_W'(1);
                end
            end
            OP_OUT: begin
                o_cell_x        <= POS_W'({r_cx, 1'b1});
                o_cell_y        <= POS_W'({r_cy, 1'b1});
                o_joined        <= r_joined;
                o_wall_x        <= r_wx;
                o_wall_y        <= r_wy;
                o_added         <= r_added;
                o_frontier_size <= FSIZE_W'(r_count);
                o_idle          <= 1'b0;
            end
            OP_IDLE_OUT: begin
                o_cell_x        <= '0;
                o_cell_y        <= '0;
                o_joined        <= 1'b0;
                o_wall_x        <= '0;
                o_wall_y        <= '0;
                o_added         <= '0;
                o_frontier_size <= '0;
                o_idle          <= 1'b1;
            end
            default: begin
                r_clr <= r_clr;
            end
        endcase
    end

    // Status back to the controller
    assign o_stat.is_start   = r_is_start;
    assign o_stat.div_busy   = div_busy;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.clr_last   = &r_clr;
    assign o_stat.nb_last    = (r_nb == 2'd3);

    // Checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAP))
        else $error("frontier count beyond capacity");

    a_move_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_MOVE) |=> (r_count == $past(r_count) - CNTW'(1)))
        else $error("move did not shrink the frontier");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_go |-> !div_busy)
        else $error("divider restarted while busy");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

endmodule

@@ design/pmc_ctrl.sv @@
// Controller: sequences the datapath through start and step requests.
module pmc_ctrl import pmc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_cmd,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR0,
        S_CLR,
        S_WP,
        S_RP,
        S_RL,
        S_MV,
        S_NB0,
        S_NB,
        S_JN,
        S_MK,
        S_OUT
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    // Hold state and the operation for the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_op <= OP_NONE;
                    if (accept) begin
                        if (i_cmd == CMD_START) begin
                            r_state <= S_CLR0;
                            r_op    <= OP_TAKE_XY;
                        end else if (i_stat.count_zero) begin
                            r_state <= S_OUT;
                            r_op    <= OP_IDLE_OUT;
                        end else begin
                            r_state <= S_WP;
                            r_op    <= OP_DIV_R;
                        end
                    end
                end
                S_CLR0: begin
                    r_op    <= OP_CLR_INIT;
                    r_state <= S_CLR;
                end
                S_CLR: begin
                    if (r_op == OP_CLR && i_stat.clr_last) begin
                        r_op    <= OP_WR_START;
                        r_state <= S_NB0;
                    end else begin
                        r_op <= OP_CLR;
                    end
                end
                S_WP: begin
                    r_op <= OP_NONE;
                    if (r_op != OP_DIV_R && !i_stat.div_busy) begin
                        r_op    <= OP_TAKE_P;
                        r_state <= S_RP;
                    end
                end
                S_RP: begin
                    r_op    <= OP_RD_PICK;
                    r_state <= S_RL;
                end
                S_RL: begin
                    r_op    <= OP_RD_LAST;
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_op    <= OP_MOVE;
                    r_state <= S_NB0;
                end
                S_NB0: begin
                    r_op    <= OP_NB_RD;
                    r_state <= S_NB;
                end
                S_NB: begin
                    if (r_op == OP_NB_RD) begin
                        r_op <= OP_NB_GET;
                    end else if (!i_stat.nb_last) begin
                        r_op <= OP_NB_RD;
                    end else if (i_stat.is_start) begin
                        r_op    <= OP_MARK;
                        r_state <= S_MK;
                    end else begin
                        r_op    <= OP_JOIN;
                        r_state <= S_JN;
                    end
                end
                S_JN: begin
                    r_op    <= OP_MARK;
                    r_state <= S_MK;
                end
                S_MK: begin
                    if (r_op == OP_MARK && i_stat.nb_last) begin
                        r_op    <= OP_OUT;
                        r_state <= S_OUT;
                    end else begin
                        r_op <= OP_MARK;
                    end
                end
                default: begin
                    r_op    <= OP_NONE;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ctrl.accept = accept;
    assign o_ctrl.op     = r_op;
    assign o_busy        = (r_state != S_IDLE);

endmodule

@@ design/prim_maze_carver.sv @@
// Top level of the randomized Prim maze carver.
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with o_valid high, and the receiver
// cannot stall it. Busy drops in time for the next request to be accepted at
// the edge at which the result is taken. For a step request, a remainder
// divider picks the frontier entry, then reads and writes of the frontier list
// and cell grid run one after another. A start request folds the start cell
// into range, then clears all 2**(2*clog2(SIDE)) entries of the cell grid
// (4096 at SIDE 64), one entry a cycle.
// A step on an empty frontier answers with o_idle set.
module prim_maze_carver import pmc_pkg::*; #(
    parameter int SIDE = SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [START_W-1:0] i_start_x,
    input  logic [START_W-1:0] i_start_y,
    input  logic [RAND_W-1:0]  i_random_word,
    output logic               o_valid,
    output logic [POS_W-1:0]   o_cell_x,
    output logic [POS_W-1:0]   o_cell_y,
    output logic               o_joined,
    output logic [POS_W-1:0]   o_wall_x,
    output logic [POS_W-1:0]   o_wall_y,
    output logic [ADDED_W-1:0] o_added,
    output logic [FSIZE_W-1:0] o_frontier_size,
    output logic               o_idle
);

    t_ctrl ctrl;
    t_stat stat;

    pmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    pmc_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cmd           (i_cmd),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_random_word   (i_random_word),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_cell_x        (o_cell_x),
        .o_cell_y        (o_cell_y),
        .o_joined        (o_joined),
        .o_wall_x        (o_wall_x),
        .o_wall_y        (o_wall_y),
        .o_added         (o_added),
        .o_frontier_size (o_frontier_size),
        .o_idle          (o_idle)
    );

endmodule
